// ===== hdl/tsgc_pkg.sv =====
// Shared types and constants for the touch swipe gesture classifier.
`timescale 1ns / 1ps
package tsgc_pkg;

  localparam int MOVE_W  = 12;
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int CODE_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Gesture codes.
  localparam logic [CODE_W-1:0] GC_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] GC_TAP   = 3'd1;
  localparam logic [CODE_W-1:0] GC_LEFT  = 3'd2;
  localparam logic [CODE_W-1:0] GC_RIGHT = 3'd3;
  localparam logic [CODE_W-1:0] GC_UP    = 3'd4;
  localparam logic [CODE_W-1:0] GC_DOWN  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN_MOVE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_MOVE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_TIME      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GESTURE_MAX_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_COOLDOWN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_REPORT_ENABLE = 3'd5;

  typedef struct packed {
    logic [MOVE_W-1:0]  swipe_min_move;
    logic [MOVE_W-1:0]  tap_max_move;
    logic [LIMIT_W-1:0] tap_max_time;
    logic [LIMIT_W-1:0] gesture_max_time;
    logic [LIMIT_W-1:0] swipe_cooldown;
    logic               tap_report_enable;
  } cfg_t;

  // Status of the gesture tracker as seen by the top level.
  typedef struct packed {
    logic active;
    logic locked;
  } trk_status_t;

endpackage

// ===== hdl/tsgc_cfg_regs.sv =====
// Configuration register file of the gesture classifier.
`timescale 1ns / 1ps
module tsgc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tsgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tsgc_pkg::cfg_t                  cfg
);
  import tsgc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SWIPE_MIN_MOVE:    cfg_nxt.swipe_min_move    = cfg_wdata[MOVE_W-1:0];
        REG_TAP_MAX_MOVE:      cfg_nxt.tap_max_move      = cfg_wdata[MOVE_W-1:0];
        REG_TAP_MAX_TIME:      cfg_nxt.tap_max_time      = cfg_wdata[LIMIT_W-1:0];
        REG_GESTURE_MAX_TIME:  cfg_nxt.gesture_max_time  = cfg_wdata[LIMIT_W-1:0];
        REG_SWIPE_COOLDOWN:    cfg_nxt.swipe_cooldown    = cfg_wdata[LIMIT_W-1:0];
        REG_TAP_REPORT_ENABLE: cfg_nxt.tap_report_enable = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_min_move    <= 12'd70;
      cfg_r.tap_max_move      <= 12'd18;
      cfg_r.tap_max_time      <= 16'd250;
      cfg_r.gesture_max_time  <= 16'd1200;
      cfg_r.swipe_cooldown    <= 16'd600;
      cfg_r.tap_report_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/tsgc_classify.sv =====
// Movement and duration classifier: tap, too long, or swipe direction.
`timescale 1ns / 1ps
module tsgc_classify #(
  parameter int COORD_BITS = 12
) (
  input  tsgc_pkg::cfg_t                     cfg,
  input  logic signed [COORD_BITS:0]         dx,
  input  logic signed [COORD_BITS:0]         dy,
  input  logic [tsgc_pkg::TIME_W-1:0]        dt,
  output logic [tsgc_pkg::CODE_W-1:0]        code
);
  import tsgc_pkg::*;

  localparam int CMP_W = (COORD_BITS > MOVE_W) ? COORD_BITS : MOVE_W;
  localparam int MUL_W = COORD_BITS + 3;

  logic [COORD_BITS:0]   dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay;
  logic [CMP_W-1:0]      ax_w, ay_w, tap_move_w, swipe_move_w;
  logic [MUL_W-1:0]      ax5, ay5, ax6, ay6;
  logic                  is_tap, too_long, horiz, vert;

  always_comb begin
    dx_neg = -dx;
    dy_neg = -dy;
    ax = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    ax_w = CMP_W'(ax);
    ay_w = CMP_W'(ay);
    tap_move_w   = CMP_W'(cfg.tap_max_move);
    swipe_move_w = CMP_W'(cfg.swipe_min_move);
    // Ratio test 1.2 done as 5*a > 6*b with shifts and adds.
    ax5 = {1'b0, ax, 2'b00} + MUL_W'(ax);
    ay5 = {1'b0, ay, 2'b00} + MUL_W'(ay);
    ax6 = {1'b0, ax, 2'b00} + {2'b00, ax, 1'b0};
    ay6 = {1'b0, ay, 2'b00} + {2'b00, ay, 1'b0};

    is_tap   = (dt <= TIME_W'(cfg.tap_max_time)) && (ax_w <= tap_move_w)
               && (ay_w <= tap_move_w);
    too_long = dt > TIME_W'(cfg.gesture_max_time);
    horiz    = (ax_w >= swipe_move_w) && (ax5 > ay6);
    vert     = (ay_w >= swipe_move_w) && (ay5 > ax6);

    if (is_tap) begin
      code = GC_TAP;
    end else if (too_long) begin
      code = GC_NONE;
    end else if (horiz) begin
      code = (!dx[COORD_BITS] && (dx != '0)) ? GC_RIGHT : GC_LEFT;
    end else if (vert) begin
      code = (!dy[COORD_BITS] && (dy != '0)) ? GC_DOWN : GC_UP;
    end else begin
      code = GC_NONE;
    end
  end

endmodule

// ===== hdl/tsgc_tracker.sv =====
// Gesture state, swipe cooldown lock and final result of one poll.
`timescale 1ns / 1ps
module tsgc_tracker #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsgc_pkg::cfg_t                cfg,
  input  logic                          step,
  input  logic                          touch_present,
  input  logic [COORD_BITS-1:0]         point_x,
  input  logic [COORD_BITS-1:0]         point_y,
  input  logic [tsgc_pkg::TIME_W-1:0]   time_ms,
  output logic [tsgc_pkg::CODE_W-1:0]   gesture_code,
  output logic signed [COORD_BITS:0]    delta_x,
  output logic signed [COORD_BITS:0]    delta_y,
  output logic [tsgc_pkg::TIME_W-1:0]   duration_ms,
  output tsgc_pkg::trk_status_t         status
);
  import tsgc_pkg::*;

  logic                  active_r, active_nxt;
  logic                  locked_r, locked_nxt;
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [COORD_BITS-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [TIME_W-1:0]     start_time_r, start_time_nxt, last_time_r, last_time_nxt;
  logic [TIME_W-1:0]     swipe_time_r, swipe_time_nxt;

  logic                  release_now, lock_held, is_swipe;
  logic [TIME_W-1:0]     since_swipe;
  logic signed [COORD_BITS:0] dx, dy;
  logic [TIME_W-1:0]     dt;
  logic [CODE_W-1:0]     raw_code;

  assign dx = $signed({1'b0, last_x_r}) - $signed({1'b0, start_x_r});
  assign dy = $signed({1'b0, last_y_r}) - $signed({1'b0, start_y_r});
  assign dt = last_time_r - start_time_r;

  tsgc_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .cfg  (cfg),
    .dx   (dx),
    .dy   (dy),
    .dt   (dt),
    .code (raw_code)
  );

  always_comb begin
    since_swipe = time_ms - swipe_time_r;
    // The lock drops first, before this poll is judged.
    lock_held   = locked_r && (since_swipe < TIME_W'(cfg.swipe_cooldown));
    release_now = !touch_present && active_r;
    is_swipe    = (raw_code != GC_NONE) && (raw_code != GC_TAP);

    active_nxt     = active_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    start_time_nxt = start_time_r;
    last_time_nxt  = last_time_r;
    swipe_time_nxt = swipe_time_r;
    locked_nxt     = lock_held;

    gesture_code = GC_NONE;
    delta_x      = '0;
    delta_y      = '0;
    duration_ms  = '0;

    if (touch_present) begin
      if (!active_r) begin
        start_x_nxt    = point_x;
        start_y_nxt    = point_y;
        start_time_nxt = time_ms;
      end
      active_nxt    = 1'b1;
      last_x_nxt    = point_x;
      last_y_nxt    = point_y;
      last_time_nxt = time_ms;
    end else if (release_now) begin
      active_nxt  = 1'b0;
      delta_x     = dx;
      delta_y     = dy;
      duration_ms = dt;
      if (raw_code == GC_TAP) begin
        gesture_code = cfg.tap_report_enable ? GC_TAP : GC_NONE;
      end else if (is_swipe && !lock_held) begin
        gesture_code   = raw_code;
        swipe_time_nxt = time_ms;
        locked_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      locked_r     <= 1'b0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      start_time_r <= '0;
      last_time_r  <= '0;
      swipe_time_r <= '0;
    end else if (step) begin
      active_r     <= active_nxt;
      locked_r     <= locked_nxt;
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      start_time_r <= start_time_nxt;
      last_time_r  <= last_time_nxt;
      swipe_time_r <= swipe_time_nxt;
    end
  end

  assign status.active = active_r;
  assign status.locked = locked_r;

endmodule

// ===== hdl/touch_swipe_gesture_classifier_core.sv =====
// Top level of the touch swipe gesture classifier: handshakes and registers.
// Path: a poll beat passes the input register, then the result register,
// before its result beat appears on the outputs.
// Throughput: one poll per cycle while out_stall is low; the single
// classify stage between the input and result registers sets that figure.
// Every poll gives exactly one result beat (code none when nothing ends).
// Synchronous active-low reset clears control and gesture state and loads
// the default thresholds.
`timescale 1ns / 1ps
module touch_swipe_gesture_classifier_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_touch_present,
  input  logic [COORD_BITS-1:0]           in_point_x,
  input  logic [COORD_BITS-1:0]           in_point_y,
  input  logic [tsgc_pkg::TIME_W-1:0]     in_time_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tsgc_pkg::CODE_W-1:0]     out_gesture_code,
  output logic signed [COORD_BITS:0]      out_delta_x,
  output logic signed [COORD_BITS:0]      out_delta_y,
  output logic [tsgc_pkg::TIME_W-1:0]     out_duration_ms,
  input  logic                            cfg_we,
  input  logic [tsgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsgc_pkg::*;

  cfg_t        cfg;
  trk_status_t trk_status;

  // Input register: holds one poll beat while the result side is stalled.
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_touch_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [TIME_W-1:0]     s1_time_r;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]     out_code_r;
  logic signed [COORD_BITS:0] out_dx_r, out_dy_r;
  logic [TIME_W-1:0]     out_dt_r;

  // Result of the poll held in the input register.
  logic [CODE_W-1:0]     res_code;
  logic signed [COORD_BITS:0] res_dx, res_dy;
  logic [TIME_W-1:0]     res_dt;

  logic in_accept, s1_move, load;

  tsgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The input register drains whenever the result register is empty or its
  // beat is being taken this cycle, so a new poll can follow every cycle.
  assign s1_move   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;
  assign load      = s1_valid_r && s1_move;

  // Gesture state advances only when its poll moves into the result register.
  tsgc_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step          (load),
    .touch_present (s1_touch_r),
    .point_x       (s1_x_r),
    .point_y       (s1_y_r),
    .time_ms       (s1_time_r),
    .gesture_code  (res_code),
    .delta_x       (res_dx),
    .delta_y       (res_dy),
    .duration_ms   (res_dt),
    .status        (trk_status)
  );

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = s1_move ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_touch_r <= in_touch_present;
      s1_x_r     <= in_point_x;
      s1_y_r     <= in_point_y;
      s1_time_r  <= in_time_ms;
    end
    if (load) begin
      out_code_r <= res_code;
      out_dx_r   <= res_dx;
      out_dy_r   <= res_dy;
      out_dt_r   <= res_dt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gesture_code = out_code_r;
  assign out_delta_x      = out_dx_r;
  assign out_delta_y      = out_dy_r;
  assign out_duration_ms  = out_dt_r;

  // An emitted swipe must leave the cooldown lock set.
  a_swipe_locks: assert property (@(posedge clk) disable iff (!rst_n)
    load && (res_code == GC_LEFT || res_code == GC_RIGHT ||
             res_code == GC_UP || res_code == GC_DOWN) |=> trk_status.locked)
    else $error("swipe emitted without setting the cooldown lock");

  // A poll with a touch present always leaves a gesture open.
  a_touch_opens: assert property (@(posedge clk) disable iff (!rst_n)
    load && s1_touch_r |=> trk_status.active)
    else $error("touch poll did not leave a gesture active");

  // Taps only come out while tap reporting is enabled.
  a_tap_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    load && (res_code == GC_TAP) |-> cfg.tap_report_enable)
    else $error("tap reported while tap reporting is disabled");

  // A swipe always carries a nonzero movement.
  a_swipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_code_r == GC_LEFT || out_code_r == GC_RIGHT ||
                    out_code_r == GC_UP || out_code_r == GC_DOWN)
    |-> (out_dx_r != '0) || (out_dy_r != '0))
    else $error("swipe result with zero movement");

endmodule
